// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
// Depends on nothing; every macro samples on clock and mutes during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/awcrg_pkg.sv =====
// Package for the add-with-carry generator: widths, op codes, offsets,
// controller states and the command/status structs. Depends on nothing.
package awcrg_pkg;

   localparam int WORD_W    = 32;
   localparam int LAG_COUNT = 6;
   localparam int IDX_W     = $clog2(LAG_COUNT);
   localparam int CNT_W     = $clog2(WORD_W);

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [1:0]        op_type;

   localparam op_type OP_RESEED = 2'd0;
   localparam op_type OP_RAW    = 2'd1;
   localparam op_type OP_RANGED = 2'd2;

   localparam idx_type IDX_LAST = idx_type'(LAG_COUNT - 1);
   localparam cnt_type CNT_LAST = cnt_type'(WORD_W - 1);

   localparam word_type LAG_OFFSETS [LAG_COUNT] = '{
      32'hf22d0e56, 32'h883126e9, 32'hc624dd2f,
      32'h0702c49c, 32'h9e353f7d, 32'h6fdf3b64
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHAIN,
      ST_INCR,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      SEL_RAW,
      SEL_SUM,
      SEL_HIGH
   } sel_type;

   typedef struct packed {
      logic    capture;
      logic    load_seed;
      logic    start_chain;
      logic    chain_step;
      logic    incr_step;
      logic    div_step;
      logic    emit;
      sel_type emit_sel;
   } cmd_type;

   typedef struct packed {
      logic delta_zero;
      logic chain_last;
      logic incr_last;
      logic div_last;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/awcrg_dp.sv =====
// Datapath: lag words, add-with-carry chain, ripple increment,
// restoring remainder unit and output register. Depends on awcrg_pkg.
module awcrg_dp
   import awcrg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  word_type          req_start_value,
   input  logic signed [31:0] req_range_low,
   input  logic signed [31:0] req_range_high,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output word_type          rsp_value
);

   word_type words_ff [LAG_COUNT];
   word_type acc_ff, lo_ff, hi_ff, delta_ff, raw_ff, div_ff, rem_ff, rsp_value_ff;
   word_type acc_in, rem_in, raw_in, inc_word, cur_word, req_delta, emit_value;
   logic     carry_ff, carry_in, rsp_valid_ff;
   idx_type  idx_ff;
   cnt_type  cnt_ff;
   logic [WORD_W:0] trial;

   assign cur_word  = words_ff[idx_ff];
   assign req_delta = word_type'(req_range_high) - word_type'(req_range_low) + 1'b1;
   assign {carry_in, acc_in} = {1'b0, acc_ff} + {1'b0, cur_word} + {{WORD_W{1'b0}}, carry_ff};
   assign inc_word  = cur_word + 1'b1;
   assign raw_in    = (idx_ff == '0) ? inc_word : words_ff[0];

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign trial  = {rem_ff, div_ff[WORD_W-1]};
   assign rem_in = (trial >= {1'b0, delta_ff}) ? word_type'(trial - {1'b0, delta_ff})
                                              : trial[WORD_W-1:0];

   always_comb begin
      unique case (cmd.emit_sel)
         SEL_RAW:  emit_value = raw_ff;
         SEL_SUM:  emit_value = rem_ff + lo_ff;
         SEL_HIGH: emit_value = hi_ff;
         default:  emit_value = raw_ff;
      endcase
   end

   assign status.delta_zero = (req_delta == '0);
   assign status.chain_last = (idx_ff == '0);
   assign status.incr_last  = (inc_word != '0) || (idx_ff == '0);
   assign status.div_last   = (cnt_ff == CNT_LAST);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAG_COUNT; i++) begin
            words_ff[i] <= LAG_OFFSETS[i];
         end
      end else if (cmd.load_seed) begin
         for (int i = 0; i < LAG_COUNT; i++) begin
            words_ff[i] <= req_start_value + LAG_OFFSETS[i];
         end
      end else if (cmd.chain_step || cmd.incr_step) begin
         for (int i = 0; i < LAG_COUNT; i++) begin
            if (idx_type'(i) == idx_ff) begin
               words_ff[i] <= cmd.chain_step ? acc_in : inc_word;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         lo_ff    <= word_type'(req_range_low);
         hi_ff    <= word_type'(req_range_high);
         delta_ff <= req_delta;
      end
      if (cmd.start_chain) begin
         acc_ff   <= words_ff[LAG_COUNT-1];
         carry_ff <= 1'b0;
         idx_ff   <= IDX_LAST - 1'b1;
      end else if (cmd.chain_step) begin
         acc_ff   <= acc_in;
         carry_ff <= carry_in;
         idx_ff   <= (idx_ff == '0) ? IDX_LAST : idx_ff - 1'b1;
      end else if (cmd.incr_step) begin
         idx_ff <= idx_ff - 1'b1;
         if (status.incr_last) begin
            raw_ff <= raw_in;
            div_ff <= raw_in;
            rem_ff <= '0;
            cnt_ff <= '0;
         end
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         div_ff <= {div_ff[WORD_W-2:0], 1'b0};
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.emit) begin
         rsp_value_ff <= emit_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule

// ===== rtl/awcrg_ctrl.sv =====
// Controller: sequences reseed, add chain, ripple increment, remainder
// steps and output transfer. Depends on awcrg_pkg.
module awcrg_ctrl
   import awcrg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  op_type     req_op,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   sel_type   sel_ff, sel_in;
   logic      ranged_ff, ranged_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         sel_ff    <= SEL_RAW;
         ranged_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         sel_ff    <= sel_in;
         ranged_ff <= ranged_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      sel_in    = sel_ff;
      ranged_in = ranged_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_op)
                  OP_RAW: begin
                     state_in  = ST_CHAIN;
                     ranged_in = 1'b0;
                  end
                  OP_RANGED: begin
                     ranged_in = 1'b1;
                     if (status.delta_zero) begin
                        state_in = ST_EMIT;
                        sel_in   = SEL_HIGH;
                     end else begin
                        state_in = ST_CHAIN;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_CHAIN: begin
            if (status.chain_last) begin
               state_in = ST_INCR;
            end
         end
         ST_INCR: begin
            if (status.incr_last) begin
               if (ranged_ff) begin
                  state_in = ST_DIVIDE;
               end else begin
                  state_in = ST_EMIT;
                  sel_in   = SEL_RAW;
               end
            end
         end
         ST_DIVIDE: begin
            if (status.div_last) begin
               state_in = ST_EMIT;
               sel_in   = SEL_SUM;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready       = 1'b0;
      cmd             = '0;
      cmd.emit_sel    = sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               unique case (req_op)
                  OP_RESEED: cmd.load_seed   = 1'b1;
                  OP_RAW:    cmd.start_chain = 1'b1;
                  OP_RANGED: cmd.start_chain = !status.delta_zero;
                  default:   cmd.load_seed   = 1'b0;
               endcase
            end
         end
         ST_CHAIN:  cmd.chain_step = 1'b1;
         ST_INCR:   cmd.incr_step  = 1'b1;
         ST_DIVIDE: cmd.div_step   = 1'b1;
         ST_EMIT:   cmd.emit       = status.out_free;
         default:   cmd.emit       = 1'b0;
      endcase
   end

endmodule

// ===== rtl/add_with_carry_random_generator.sv =====
// Add-with-carry lagged random generator, top level.
// Depends on awcrg_pkg, awcrg_ctrl, awcrg_dp and assert_macros.svh.
//
// Usage: requests arrive on req_* (valid/ready); op 0 reseeds the six lag
// words from req_start_value plus fixed offsets and returns nothing, op 1
// returns a raw 32-bit word, op 2 returns a word in [range_low, range_high]
// (two's complement, inclusive), op 3 is dropped. Results leave on rsp_*.
// Reseed and op 3 finish in the transfer cycle; a raw draw runs five chained
// adds, one to six ripple increment steps and one output load; a ranged draw
// adds the one-bit-per-cycle remainder unit; a full 32-bit range skips
// straight to the output load and returns range_high.
// One request is in work at a time; req_ready returns together with
// rsp_valid once the result is loaded into the output register.
// Reset (synchronous) loads the offsets as the lag words and empties the
// output register. A stalled receiver holds rsp_value; a finished result
// then waits in the controller until the output register frees up, and no
// new request is taken meanwhile.
`include "assert_macros.svh"

module add_with_carry_random_generator
   import awcrg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_op,
   input  logic [31:0]       req_start_value,
   input  logic signed [31:0] req_range_low,
   input  logic signed [31:0] req_range_high,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [31:0]       rsp_value
);

   cmd_type    cmd;
   status_type status;

   awcrg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .status    (status),
      .cmd       (cmd)
   );

   awcrg_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_start_value (req_start_value),
      .req_range_low   (req_range_low),
      .req_range_high  (req_range_high),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_value       (rsp_value)
   );

   `ASSERT_SAME(a_busy_not_ready, cmd.chain_step || cmd.incr_step || cmd.div_step, !req_ready)
   `ASSERT_SAME(a_emit_slot_free, cmd.emit, status.out_free)
   `ASSERT_NEXT(a_emit_shows, cmd.emit, rsp_valid)

endmodule
